>>> rtl/kpm_pkg.sv
package kpm_pkg;

  // Default window width for interval and expected-gap compares
  localparam int GAP_BITS_DEF = 16;

  localparam int FIELD_W = 16;
  localparam int POS_W   = 3;
  localparam int CFG_IDX_W = 3;

  // Knocks matched before the final one completes the pattern
  localparam logic [POS_W-1:0] PATTERN_STEPS = 3'd4;

  // Register reset values
  localparam logic [FIELD_W-1:0] GAP_1_RST     = 16'd6000;
  localparam logic [FIELD_W-1:0] GAP_2_RST     = 16'd6000;
  localparam logic [FIELD_W-1:0] GAP_3_RST     = 16'd3000;
  localparam logic [FIELD_W-1:0] GAP_4_RST     = 16'd3000;
  localparam logic [FIELD_W-1:0] TOLERANCE_RST = 16'd1200;
  localparam logic [FIELD_W-1:0] IDLE_LIM_RST  = 16'd375;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_1     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_2     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_3     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_4     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIM  = 3'd5;

  // Request kinds
  localparam logic FUNC_KNOCK = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_STEP    = 3'd1,
    EV_DONE    = 3'd2,
    EV_REJECT  = 3'd3,
    EV_TIMEOUT = 3'd4
  } kpm_event_t;

endpackage

>>> rtl/knock_pattern_matcher_core.sv
// A request is held in the input register, and its result in the result register that drives the outputs.
// Throughput: one request per cycle while the result channel does not stall; the
//   combinational compare of the interval against its window, between the input
//   register and the result register, sets that rate.
// Reset (synchronous, rst_n low): sequence, lockout, counters and indicators
//   clear, configuration returns to its default intervals and limits.
module knock_pattern_matcher_core
  import kpm_pkg::*;
#(
  parameter int GAP_BITS = GAP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,

  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  logic [FIELD_W-1:0]   in_interval,

  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_event_res,
  output logic                 out_red_led,
  output logic                 out_green_led,
  output logic                 out_unlock,
  output logic [POS_W-1:0]     out_position,
  output logic [FIELD_W-1:0]   out_fail_count,

  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data
);

  // Only the low GAP_W bits of interval and expected gaps take part in the compare
  localparam int GAP_W = (GAP_BITS < FIELD_W) ? GAP_BITS : FIELD_W;
  localparam int WIN_W = FIELD_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [GAP_W-1:0]   gap_r [4];
  logic [FIELD_W-1:0] tol_r;
  logic [FIELD_W-1:0] idle_lim_r;

  // The user must write configuration only while the block is idle; the block does not enforce this and always takes it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r[0]   <= GAP_W'(GAP_1_RST);
      gap_r[1]   <= GAP_W'(GAP_2_RST);
      gap_r[2]   <= GAP_W'(GAP_3_RST);
      gap_r[3]   <= GAP_W'(GAP_4_RST);
      tol_r      <= TOLERANCE_RST;
      idle_lim_r <= IDLE_LIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GAP_1:     gap_r[0]   <= cfg_data[GAP_W-1:0];
        CFG_GAP_2:     gap_r[1]   <= cfg_data[GAP_W-1:0];
        CFG_GAP_3:     gap_r[2]   <= cfg_data[GAP_W-1:0];
        CFG_GAP_4:     gap_r[3]   <= cfg_data[GAP_W-1:0];
        CFG_TOLERANCE: tol_r      <= cfg_data;
        CFG_IDLE_LIM:  idle_lim_r <= cfg_data;
        default: ;  // unused indexes: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic               in_vld_r;
  logic               func_r;
  logic [GAP_W-1:0]   interval_r;
  logic               advance;   // the input register hands its request to the result register
  logic               take_in;

  assign advance  = in_vld_r && (!out_valid || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign take_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (take_in) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      func_r     <= in_func;
      interval_r <= in_interval[GAP_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Matcher state
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]   pos_r,    pos_nxt;
  logic               locked_r, locked_nxt;
  logic [FIELD_W-1:0] idle_r,   idle_nxt;
  logic [FIELD_W-1:0] fail_r,   fail_nxt;
  logic               red_r,    red_nxt;
  logic               green_r,  green_nxt;
  logic               unlock_r, unlock_nxt;
  kpm_event_t         event_r,  event_nxt;
  logic               out_vld_r;

  // Window around the expected gap for the current position
  logic [1:0]         slot;
  logic [WIN_W-1:0]   gap_w;
  logic [WIN_W-1:0]   tol_w;
  logic [WIN_W-1:0]   val_w;
  logic [WIN_W-1:0]   win_lo;
  logic [WIN_W-1:0]   win_hi;
  logic               in_win;
  logic               take;

  always_comb begin
    slot   = 2'(pos_r - 3'd1);
    gap_w  = WIN_W'(gap_r[slot]);
    tol_w  = WIN_W'(tol_r);
    val_w  = WIN_W'(interval_r);
    // lower bound clamps at zero, upper bound has a spare bit so it never wraps
    win_lo = (gap_w > tol_w) ? (gap_w - tol_w) : '0;
    win_hi = gap_w + tol_w;
    in_win = (val_w >= win_lo) && (val_w <= win_hi);
    // opening knock is trusted unless locked out
    take   = (pos_r == '0) ? !locked_r : in_win;
  end

  always_comb begin
    pos_nxt    = pos_r;
    locked_nxt = locked_r;
    idle_nxt   = idle_r;
    fail_nxt   = fail_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    unlock_nxt = unlock_r;
    event_nxt  = EV_NONE;

    if (func_r == FUNC_KNOCK) begin
      // every knock clears the indicators and restarts the idle count
      idle_nxt   = '0;
      red_nxt    = 1'b0;
      green_nxt  = 1'b0;
      unlock_nxt = 1'b0;
      if (!take) begin
        fail_nxt   = fail_r + 1'b1;
        pos_nxt    = '0;
        locked_nxt = 1'b1;
        event_nxt  = EV_REJECT;
      end else if (pos_r < PATTERN_STEPS) begin
        pos_nxt   = pos_r + 1'b1;
        event_nxt = EV_STEP;
      end else begin
        green_nxt  = 1'b1;
        unlock_nxt = 1'b1;
        pos_nxt    = '0;
        fail_nxt   = '0;
        event_nxt  = EV_DONE;
      end
    end else if (idle_r < idle_lim_r) begin
      idle_nxt = idle_r + 1'b1;
    end else begin
      // idle timeout: restart, lift the lockout, flag red if it was set
      red_nxt    = locked_r;
      idle_nxt   = '0;
      pos_nxt    = '0;
      locked_nxt = 1'b0;
      event_nxt  = EV_TIMEOUT;
    end
  end

  // State only moves when the result register loads, so the state registers
  // double as the stalled result payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      locked_r  <= 1'b0;
      idle_r    <= '0;
      fail_r    <= '0;
      red_r     <= 1'b0;
      green_r   <= 1'b0;
      unlock_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (advance) begin
        pos_r    <= pos_nxt;
        locked_r <= locked_nxt;
        idle_r   <= idle_nxt;
        fail_r   <= fail_nxt;
        red_r    <= red_nxt;
        green_r  <= green_nxt;
        unlock_r <= unlock_nxt;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_r <= event_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_event_res  = event_r;
  assign out_red_led    = red_r;
  assign out_green_led  = green_r;
  assign out_unlock     = unlock_r;
  assign out_position   = pos_r;
  assign out_fail_count = fail_r;

endmodule

>>> rtl/kpm_checker.sv
module kpm_checker
  import kpm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_event_res,
  input logic               out_red_led,
  input logic               out_green_led,
  input logic               out_unlock,
  input logic [POS_W-1:0]   out_position,
  input logic [FIELD_W-1:0] out_fail_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_res)
      && $stable(out_position) && $stable(out_fail_count))
    else $error("stalled result changed");

  // green and the solenoid drive are always set and cleared together
  a_green_unlock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_green_led == out_unlock)
    else $error("green and unlock disagree");

  // completion restarts the sequence and clears failures
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_DONE |->
      out_position == '0 && out_fail_count == '0 && out_green_led && !out_red_led)
    else $error("completion result inconsistent");

  // a rejected knock restarts the sequence with all indicators off
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_REJECT |->
      out_position == '0 && !out_green_led && !out_red_led && !out_unlock)
    else $error("rejection result inconsistent");

  // a step result leaves the position between one and PATTERN_STEPS with green off
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_STEP |->
      out_position != '0 && out_position <= PATTERN_STEPS && !out_green_led)
    else $error("step result inconsistent");

endmodule

bind knock_pattern_matcher_core kpm_checker u_kpm_checker (.*);
